// ----- rtl/core/sparse_matrix_multiply_macros.svh -----
// ----------------------------------------------------------------------------
// Sparse matrix multiply assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SPARSE_MATRIX_MULTIPLY_MACROS_SVH
`define SPARSE_MATRIX_MULTIPLY_MACROS_SVH

`ifndef SYNTHESIS
`define SMM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("smm assertion failed");
`define SMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smm assertion failed");
`else
`define SMM_ASSERT(lbl, clk, rst_n, prop)
`define SMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/smm_pkg.sv -----
// ----------------------------------------------------------------------------
// Sparse matrix multiply package
// Widths, codes, term formats and controller states shared by the block.
// ----------------------------------------------------------------------------
package smm_pkg;

  localparam int MAX_TERMS_DEF = 1024;
  localparam int MAX_DIM       = 256;
  localparam int DIM_W         = 9;
  localparam int RC_W          = 8;
  localparam int VAL_W         = 16;
  localparam int PROD_W        = 32;
  localparam int IDX_W         = 10;
  localparam int CMD_W         = 3;
  localparam int STAT_W        = 2;
  localparam int TCNT_W        = 11;
  localparam int POS_W         = 18;
  localparam int LPOS_W        = 16;
  localparam int CFG_IDX_W     = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD_A  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ_C  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ_S  = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVF   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_A_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COLS = 2'd3;

  typedef struct packed {
    logic [RC_W-1:0]         r;
    logic [RC_W-1:0]         c;
    logic signed [VAL_W-1:0] v;
  } trip_t;

  typedef struct packed {
    logic [RC_W-1:0]   r;
    logic [RC_W-1:0]   c;
    logic [PROD_W-1:0] v;
  } ctrip_t;

  typedef struct packed {
    logic [DIM_W-1:0] a_rows;
    logic [DIM_W-1:0] a_cols;
    logic [DIM_W-1:0] b_rows;
    logic [DIM_W-1:0] b_cols;
  } dims_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [RC_W-1:0]   row;
    logic [RC_W-1:0]   col;
    logic [PROD_W-1:0] product;
    logic [TCNT_W-1:0] term_count;
  } res_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LD_DIV, S_RESP, S_CLR,
    S_CNT_A, S_CNT_B, S_CNT_C,
    S_ST_A, S_ST_B,
    S_TR_A, S_TR_B, S_TR_C,
    S_MA_A, S_MB_A, S_MB_B, S_SR_A, S_SR_B
  } state_t;

  typedef enum logic [1:0] {SRC_NONE, SRC_CTERM, SRC_START} src_t;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] d;
    if (v == '0) begin
      d = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      d = DIM_W'(MAX_DIM);
    end else begin
      d = v;
    end
    return d;
  endfunction

endpackage

// ----- rtl/core/sparse_matrix_multiply.sv -----
// ----------------------------------------------------------------------------
// Sparse matrix multiply
// Triplet-store sparse product with fast transpose of B, command driven.
// ----------------------------------------------------------------------------
//  channel | dir | signals                          | contents
//  in      | in  | in_tvalid/tready/tdata/tuser     | command, value, index
//  out     | out | out_tvalid/tready/tdata/tuser    | status, row, col, product, count
//  cfg     | in  | cfg_we/cfg_index/cfg_data        | a_rows, a_cols, b_rows, b_cols
//
//  Reads, zero loads and rejected words go straight to the response; a stored
//  nonzero load first waits on the bit-serial position divider.
//  Compute time grows with the B terms, the A terms and, per match, the C search
//  length, as it runs over the single-port term and tally memories.
//  Reset is synchronous; stores are not cleared. Output register holds a word
//  while out_tready is low; the next input word is still taken, but its result waits.
// ----------------------------------------------------------------------------
module sparse_matrix_multiply #(
  parameter int MAX_TERMS = smm_pkg::MAX_TERMS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [31:0]                       in_tdata,   // value[15:0], index[25:16]
  input  logic [smm_pkg::CMD_W-1:0]         in_tuser,   // command[2:0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [63:0]                       out_tdata,  // row, col, product, term_count
  output logic [smm_pkg::STAT_W-1:0]        out_tuser,  // status[1:0]
  input  logic                              cfg_we,
  input  logic [smm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [smm_pkg::DIM_W-1:0]         cfg_data
);

  smm_pkg::dims_t dims_r;
  smm_pkg::res_t  res;
  logic           res_valid;
  logic           res_ready;
  logic           out_valid_r;
  logic [63:0]    out_data_r;
  logic [smm_pkg::STAT_W-1:0] out_stat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r.a_rows <= smm_pkg::DIM_W'(1);
      dims_r.a_cols <= smm_pkg::DIM_W'(1);
      dims_r.b_rows <= smm_pkg::DIM_W'(1);
      dims_r.b_cols <= smm_pkg::DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        smm_pkg::CFG_A_ROWS: dims_r.a_rows <= smm_pkg::clamp_dim(cfg_data);
        smm_pkg::CFG_A_COLS: dims_r.a_cols <= smm_pkg::clamp_dim(cfg_data);
        smm_pkg::CFG_B_ROWS: dims_r.b_rows <= smm_pkg::clamp_dim(cfg_data);
        smm_pkg::CFG_B_COLS: dims_r.b_cols <= smm_pkg::clamp_dim(cfg_data);
        default: dims_r <= dims_r;
      endcase
    end
  end

  smm_core #(
    .MAX_TERMS (MAX_TERMS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tuser),
    .in_value  (in_tdata[15:0]),
    .in_index  (in_tdata[25:16]),
    .dims      (dims_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= {5'b0, res.term_count, res.product, res.col, res.row};
      out_stat_r <= res.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

endmodule

// ----- rtl/core/smm_div.sv -----
// ----------------------------------------------------------------------------
// Sparse matrix multiply position divider
// Restoring divider, one quotient bit a cycle: position into row and column.
// ----------------------------------------------------------------------------
module smm_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [smm_pkg::LPOS_W-1:0]    dividend,
  input  logic [smm_pkg::DIM_W-1:0]     divisor,
  output logic                          done,
  output logic [smm_pkg::LPOS_W-1:0]    quot,
  output logic [smm_pkg::DIM_W-1:0]     rem
);

  localparam int CNT_W = $clog2(smm_pkg::LPOS_W + 1);

  logic                          busy_r;
  logic                          done_r;
  logic [CNT_W-1:0]              cnt_r;
  logic [smm_pkg::LPOS_W-1:0]    quo_r;
  logic [smm_pkg::DIM_W-1:0]     rem_r;
  logic [smm_pkg::DIM_W-1:0]     dvs_r;
  logic [smm_pkg::DIM_W:0]       trial;
  logic                          ge;
  logic [smm_pkg::DIM_W-1:0]     rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[smm_pkg::LPOS_W-1]};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? smm_pkg::DIM_W'(trial - {1'b0, dvs_r}) : smm_pkg::DIM_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(smm_pkg::LPOS_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[smm_pkg::LPOS_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

// ----- rtl/core/smm_core.sv -----
// ----------------------------------------------------------------------------
// Sparse matrix multiply core
// Term stores, column tally and start memories, and the sequencer over them.
// ----------------------------------------------------------------------------
`include "sparse_matrix_multiply_macros.svh"

module smm_core #(
  parameter int MAX_TERMS = smm_pkg::MAX_TERMS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [smm_pkg::CMD_W-1:0]     in_cmd,
  input  logic [smm_pkg::VAL_W-1:0]     in_value,
  input  logic [smm_pkg::IDX_W-1:0]     in_index,
  input  smm_pkg::dims_t                dims,
  output logic                          res_valid,
  input  logic                          res_ready,
  output smm_pkg::res_t                 res
);

  localparam int IW = $clog2(MAX_TERMS);
  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int DW = $clog2(smm_pkg::MAX_DIM);
  localparam logic [DW-1:0] DIM_LAST = DW'(smm_pkg::MAX_DIM - 1);

  smm_pkg::trip_t  a_mem [MAX_TERMS];
  smm_pkg::trip_t  b_mem [MAX_TERMS];
  smm_pkg::trip_t  t_mem [MAX_TERMS];
  smm_pkg::ctrip_t c_mem [MAX_TERMS];
  logic [CW-1:0]   tally_mem [smm_pkg::MAX_DIM];
  logic [CW-1:0]   start_mem [smm_pkg::MAX_DIM];

  smm_pkg::trip_t  a_q, b_q, t_q;
  smm_pkg::ctrip_t c_q;
  logic [CW-1:0]   tally_q, start_q;

  logic a_we, b_we, t_we, c_we, tally_we, start_we;
  logic a_re, b_re, t_re, c_re, tally_re, start_re;
  logic [IW-1:0] a_waddr, b_waddr, t_waddr, c_waddr;
  logic [IW-1:0] a_raddr, b_raddr, t_raddr, c_raddr;
  logic [DW-1:0] tally_waddr, tally_raddr, start_waddr, start_raddr;
  smm_pkg::trip_t  ab_wdata, t_wdata;
  smm_pkg::ctrip_t c_wdata;
  logic [CW-1:0]   tally_wdata;

  smm_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] a_cnt_r, a_cnt_nxt, b_cnt_r, b_cnt_nxt, c_cnt_r, c_cnt_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, run_r, run_nxt;
  logic [DW-1:0] col_r, col_nxt;
  logic [smm_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic ovf_r, ovf_nxt, ld_b_r, ld_b_nxt;
  logic signed [smm_pkg::VAL_W-1:0] val_r, val_nxt;
  logic [smm_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [smm_pkg::STAT_W-1:0] stat_r, stat_nxt;
  smm_pkg::src_t src_r, src_nxt;

  logic [smm_pkg::POS_W-1:0] a_size, b_size, b_off;
  logic is_a, is_b, ld_ok, ld_go, rdc_ok, rds_ok;
  logic [CW-1:0] ld_cnt;
  logic [smm_pkg::LPOS_W-1:0] div_dividend;
  logic [smm_pkg::DIM_W-1:0] div_divisor;
  logic div_start, div_done;
  logic [smm_pkg::LPOS_W-1:0] div_quot;
  logic [smm_pkg::DIM_W-1:0] div_rem;

  smm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_comb begin
    a_size = smm_pkg::POS_W'(dims.a_rows) * smm_pkg::POS_W'(dims.a_cols);
    b_size = smm_pkg::POS_W'(dims.b_rows) * smm_pkg::POS_W'(dims.b_cols);
    b_off  = pos_r - a_size;
    is_a   = (in_cmd == smm_pkg::CMD_LOAD_A) && (pos_r < a_size);
    is_b   = (in_cmd == smm_pkg::CMD_LOAD_B) && (pos_r >= a_size) && (b_off < b_size);
    ld_ok  = is_a || is_b;
    if (pos_r == '0) begin
      ld_cnt = '0;
    end else begin
      ld_cnt = is_a ? a_cnt_r : b_cnt_r;
    end
    ld_go  = ld_ok && (in_value != '0) && (32'(ld_cnt) < MAX_TERMS);
    rdc_ok = (32'(in_index) < 32'(c_cnt_r)) && (32'(in_index) < MAX_TERMS);
    rds_ok = (32'(in_index) < 32'(dims.b_cols)) && (32'(in_index) < smm_pkg::MAX_DIM);
    div_dividend = is_a ? pos_r[smm_pkg::LPOS_W-1:0] : b_off[smm_pkg::LPOS_W-1:0];
    div_divisor  = is_a ? dims.a_cols : dims.b_cols;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      smm_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_cmd == smm_pkg::CMD_COMPUTE) begin
            state_nxt = smm_pkg::S_CLR;
          end else if (((in_cmd == smm_pkg::CMD_LOAD_A) || (in_cmd == smm_pkg::CMD_LOAD_B))
                       && ld_go) begin
            state_nxt = smm_pkg::S_LD_DIV;
          end else begin
            state_nxt = smm_pkg::S_RESP;
          end
        end
      end
      smm_pkg::S_LD_DIV: if (div_done) state_nxt = smm_pkg::S_RESP;
      smm_pkg::S_RESP:   if (res_ready) state_nxt = smm_pkg::S_IDLE;
      smm_pkg::S_CLR:    if (col_r == DIM_LAST) state_nxt = smm_pkg::S_CNT_A;
      smm_pkg::S_CNT_A:  state_nxt = (i_r == b_cnt_r) ? smm_pkg::S_ST_A : smm_pkg::S_CNT_B;
      smm_pkg::S_CNT_B:  state_nxt = smm_pkg::S_CNT_C;
      smm_pkg::S_CNT_C:  state_nxt = smm_pkg::S_CNT_A;
      smm_pkg::S_ST_A:   state_nxt = smm_pkg::S_ST_B;
      smm_pkg::S_ST_B:   state_nxt = (col_r == DIM_LAST) ? smm_pkg::S_TR_A : smm_pkg::S_ST_A;
      smm_pkg::S_TR_A:   state_nxt = (i_r == b_cnt_r) ? smm_pkg::S_MA_A : smm_pkg::S_TR_B;
      smm_pkg::S_TR_B:   state_nxt = smm_pkg::S_TR_C;
      smm_pkg::S_TR_C:   state_nxt = smm_pkg::S_TR_A;
      smm_pkg::S_MA_A:   state_nxt = (i_r == a_cnt_r) ? smm_pkg::S_RESP : smm_pkg::S_MB_A;
      smm_pkg::S_MB_A:   state_nxt = (j_r == b_cnt_r) ? smm_pkg::S_MA_A : smm_pkg::S_MB_B;
      smm_pkg::S_MB_B:   state_nxt = (a_q.c != t_q.c) ? smm_pkg::S_MB_A : smm_pkg::S_SR_A;
      smm_pkg::S_SR_A:   state_nxt = (k_r == c_cnt_r) ? smm_pkg::S_MB_A : smm_pkg::S_SR_B;
      smm_pkg::S_SR_B: begin
        if ((c_q.r == a_q.r) && (c_q.c == t_q.r)) begin
          state_nxt = smm_pkg::S_MB_A;
        end else begin
          state_nxt = smm_pkg::S_SR_A;
        end
      end
      default: state_nxt = smm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    a_cnt_nxt = a_cnt_r;  b_cnt_nxt = b_cnt_r;  c_cnt_nxt = c_cnt_r;
    i_nxt = i_r;  j_nxt = j_r;  k_nxt = k_r;  run_nxt = run_r;  col_nxt = col_r;
    pos_nxt = pos_r;  ovf_nxt = ovf_r;  ld_b_nxt = ld_b_r;  val_nxt = val_r;
    prod_nxt = prod_r;  stat_nxt = stat_r;  src_nxt = src_r;
    div_start = 1'b0;
    a_we = 1'b0;  b_we = 1'b0;  t_we = 1'b0;  c_we = 1'b0;
    tally_we = 1'b0;  start_we = 1'b0;
    a_re = 1'b0;  b_re = 1'b0;  t_re = 1'b0;  c_re = 1'b0;
    tally_re = 1'b0;  start_re = 1'b0;
    a_waddr = a_cnt_r[IW-1:0];
    b_waddr = b_cnt_r[IW-1:0];
    ab_wdata = '{r: div_quot[smm_pkg::RC_W-1:0], c: div_rem[smm_pkg::RC_W-1:0], v: val_r};
    t_waddr = tally_q[IW-1:0];
    t_wdata = '{r: b_q.c, c: b_q.r, v: b_q.v};
    c_waddr = k_r[IW-1:0];
    c_wdata = '{r: c_q.r, c: c_q.c, v: c_q.v + prod_r};
    a_raddr = i_r[IW-1:0];
    b_raddr = i_r[IW-1:0];
    t_raddr = j_r[IW-1:0];
    c_raddr = k_r[IW-1:0];
    tally_waddr = b_q.c;
    tally_raddr = b_q.c;
    tally_wdata = tally_q + CW'(1);
    start_waddr = col_r;
    start_raddr = in_index[DW-1:0];
    res_valid = 1'b0;
    case (state_r)
      smm_pkg::S_IDLE: begin
        if (in_valid) begin
          src_nxt  = smm_pkg::SRC_NONE;
          stat_nxt = smm_pkg::STAT_RANGE;
          case (in_cmd)
            smm_pkg::CMD_LOAD_A, smm_pkg::CMD_LOAD_B: begin
              if (pos_r == '0) begin
                a_cnt_nxt = '0;
                b_cnt_nxt = '0;
                c_cnt_nxt = '0;
              end
              if (ld_ok) begin
                pos_nxt  = pos_r + smm_pkg::POS_W'(1);
                stat_nxt = (in_value == '0 || ld_go) ? smm_pkg::STAT_OK : smm_pkg::STAT_OVF;
                if (ld_go) begin
                  div_start = 1'b1;
                  ld_b_nxt  = !is_a;
                  val_nxt   = in_value;
                end
              end
            end
            smm_pkg::CMD_COMPUTE: begin
              col_nxt = '0;
              ovf_nxt = 1'b0;
            end
            smm_pkg::CMD_READ_C: begin
              if (rdc_ok) begin
                c_re     = 1'b1;
                c_raddr  = IW'(in_index);
                src_nxt  = smm_pkg::SRC_CTERM;
                stat_nxt = smm_pkg::STAT_OK;
              end
            end
            smm_pkg::CMD_READ_S: begin
              if (rds_ok) begin
                start_re = 1'b1;
                src_nxt  = smm_pkg::SRC_START;
                stat_nxt = smm_pkg::STAT_OK;
              end
            end
            default: stat_nxt = smm_pkg::STAT_RANGE;
          endcase
        end
      end
      smm_pkg::S_LD_DIV: begin
        if (div_done) begin
          if (ld_b_r) begin
            b_we      = 1'b1;
            b_cnt_nxt = b_cnt_r + CW'(1);
          end else begin
            a_we      = 1'b1;
            a_cnt_nxt = a_cnt_r + CW'(1);
          end
        end
      end
      smm_pkg::S_RESP: res_valid = 1'b1;
      smm_pkg::S_CLR: begin
        tally_we    = 1'b1;
        tally_waddr = col_r;
        tally_wdata = '0;
        col_nxt     = col_r + DW'(1);
        i_nxt       = '0;
      end
      smm_pkg::S_CNT_A: begin
        if (i_r == b_cnt_r) begin
          col_nxt = '0;
          run_nxt = '0;
        end else begin
          b_re = 1'b1;
        end
      end
      smm_pkg::S_CNT_B, smm_pkg::S_TR_B: tally_re = 1'b1;
      smm_pkg::S_CNT_C: begin
        tally_we = 1'b1;
        i_nxt    = i_r + CW'(1);
      end
      smm_pkg::S_ST_A: begin
        tally_re    = 1'b1;
        tally_raddr = col_r;
      end
      smm_pkg::S_ST_B: begin
        tally_we    = 1'b1;
        tally_waddr = col_r;
        tally_wdata = run_r;
        start_we    = 1'b1;
        run_nxt     = run_r + tally_q;
        col_nxt     = col_r + DW'(1);
        i_nxt       = '0;
      end
      smm_pkg::S_TR_A: begin
        if (i_r == b_cnt_r) begin
          i_nxt     = '0;
          c_cnt_nxt = '0;
        end else begin
          b_re = 1'b1;
        end
      end
      smm_pkg::S_TR_C: begin
        tally_we = 1'b1;
        t_we     = 32'(tally_q) < MAX_TERMS;
        i_nxt    = i_r + CW'(1);
      end
      smm_pkg::S_MA_A: begin
        if (i_r == a_cnt_r) begin
          pos_nxt  = '0;
          src_nxt  = smm_pkg::SRC_NONE;
          stat_nxt = ovf_r ? smm_pkg::STAT_OVF : smm_pkg::STAT_OK;
        end else begin
          a_re  = 1'b1;
          j_nxt = '0;
        end
      end
      smm_pkg::S_MB_A: begin
        if (j_r == b_cnt_r) begin
          i_nxt = i_r + CW'(1);
        end else begin
          t_re = 1'b1;
        end
      end
      smm_pkg::S_MB_B: begin
        if (a_q.c != t_q.c) begin
          j_nxt = j_r + CW'(1);
        end else begin
          prod_nxt = smm_pkg::PROD_W'(a_q.v * t_q.v);
          k_nxt    = '0;
        end
      end
      smm_pkg::S_SR_A: begin
        if (k_r == c_cnt_r) begin
          j_nxt = j_r + CW'(1);
          if (32'(c_cnt_r) < MAX_TERMS) begin
            c_we      = 1'b1;
            c_waddr   = c_cnt_r[IW-1:0];
            c_wdata   = '{r: a_q.r, c: t_q.r, v: prod_r};
            c_cnt_nxt = c_cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end else begin
          c_re = 1'b1;
        end
      end
      smm_pkg::S_SR_B: begin
        if ((c_q.r == a_q.r) && (c_q.c == t_q.r)) begin
          c_we  = 1'b1;
          j_nxt = j_r + CW'(1);
        end else begin
          k_nxt = k_r + CW'(1);
        end
      end
      default: res_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smm_pkg::S_IDLE;
      a_cnt_r <= '0;
      b_cnt_r <= '0;
      c_cnt_r <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      a_cnt_r <= a_cnt_nxt;
      b_cnt_r <= b_cnt_nxt;
      c_cnt_r <= c_cnt_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    k_r    <= k_nxt;
    run_r  <= run_nxt;
    col_r  <= col_nxt;
    ovf_r  <= ovf_nxt;
    ld_b_r <= ld_b_nxt;
    val_r  <= val_nxt;
    prod_r <= prod_nxt;
    stat_r <= stat_nxt;
    src_r  <= src_nxt;
  end

  always_ff @(posedge clk) begin
    if (a_we) a_mem[a_waddr] <= ab_wdata;
    if (a_re) a_q <= a_mem[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (b_we) b_mem[b_waddr] <= ab_wdata;
    if (b_re) b_q <= b_mem[b_raddr];
  end

  always_ff @(posedge clk) begin
    if (t_we) t_mem[t_waddr] <= t_wdata;
    if (t_re) t_q <= t_mem[t_raddr];
  end

  always_ff @(posedge clk) begin
    if (c_we) c_mem[c_waddr] <= c_wdata;
    if (c_re) c_q <= c_mem[c_raddr];
  end

  always_ff @(posedge clk) begin
    if (tally_we) tally_mem[tally_waddr] <= tally_wdata;
    if (tally_re) tally_q <= tally_mem[tally_raddr];
  end

  always_ff @(posedge clk) begin
    if (start_we) start_mem[start_waddr] <= run_r;
    if (start_re) start_q <= start_mem[start_raddr];
  end

  assign in_ready = (state_r == smm_pkg::S_IDLE);

  always_comb begin
    res.status     = stat_r;
    res.term_count = smm_pkg::TCNT_W'(c_cnt_r);
    res.row        = '0;
    res.col        = '0;
    res.product    = '0;
    case (src_r)
      smm_pkg::SRC_CTERM: begin
        res.row     = c_q.r;
        res.col     = c_q.c;
        res.product = c_q.v;
      end
      smm_pkg::SRC_START: res.product = smm_pkg::PROD_W'(start_q);
      default: res.product = '0;
    endcase
  end

  `SMM_ASSERT(a_div_done_in_load, clk, rst_n, !div_done || (state_r == smm_pkg::S_LD_DIV))
  `SMM_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_valid && in_ready, state_r != smm_pkg::S_IDLE)
  `SMM_ASSERT(a_c_count_bound, clk, rst_n, 32'(c_cnt_r) <= MAX_TERMS)
  `SMM_ASSERT(a_ab_count_bound, clk, rst_n, (32'(a_cnt_r) <= MAX_TERMS) && (32'(b_cnt_r) <= MAX_TERMS))

endmodule
